// ----- rtl/core/weighted_keyword_classifier_defines.svh -----
// Assertion macros for the weighted keyword classifier.
// Used by the top level; expects clk and rst in scope.
`ifndef WEIGHTED_KEYWORD_CLASSIFIER_DEFINES_SVH
`define WEIGHTED_KEYWORD_CLASSIFIER_DEFINES_SVH

// same-cycle implication
`define WKC_ASSERT_IMP(name, pre, post) \
  name: assert property (@(posedge clk) disable iff (rst) (pre) |-> (post)) \
    else $error("wkc assertion failed");

// next-cycle implication
`define WKC_ASSERT_NXT(name, pre, post) \
  name: assert property (@(posedge clk) disable iff (rst) (pre) |=> (post)) \
    else $error("wkc assertion failed");

`endif

// ----- rtl/core/wkc_pkg.sv -----
// Shared types, codes and helper functions for the keyword classifier.
// No dependencies.
package wkc_pkg;

  typedef enum logic [1:0] {
    CMD_CHAR = 2'd0,
    CMD_KW   = 2'd1,
    CMD_TEXT = 2'd2,
    CMD_END  = 2'd3
  } cmd_t;

  typedef enum logic [1:0] {
    OP_CHAR   = 2'd0,
    OP_KW     = 2'd1,
    OP_MATCH  = 2'd2,
    OP_REPORT = 2'd3
  } op_kind_t;

  typedef enum logic [2:0] {
    BK_CLEAR  = 3'd0,
    BK_IDLE   = 3'd1,
    BK_MATCH  = 3'd2,
    BK_DRAIN  = 3'd3,
    BK_REPORT = 3'd4
  } bk_state_t;

  typedef logic signed [47:0] score_t;
  typedef logic signed [31:0] weight_t;

  typedef struct packed {
    op_kind_t    kind;
    logic        flush;
    logic [3:0]  category;
    logic [5:0]  slot;
    logic [4:0]  position;
    logic [7:0]  byte_value;
    logic [5:0]  keyword_length;
    weight_t     weight;
  } wkc_op_t;

  localparam score_t SCORE_MAX = 48'sh7FFF_FFFF_FFFF;
  localparam score_t SCORE_MIN = 48'sh8000_0000_0000;

  function automatic logic is_delim(input logic [7:0] c);
    logic d;
    case (c)
      8'h00, 8'h09, 8'h0A, 8'h2E, 8'h2C, 8'h3B, 8'h21, 8'h3F, 8'h5C, 8'h22,
      8'h27, 8'h28, 8'h29, 8'h5B, 8'h5D, 8'h7B, 8'h7D, 8'h3A, 8'h2D, 8'h20: d = 1'b1;
      default: d = 1'b0;
    endcase
    return d;
  endfunction

  function automatic logic [7:0] fold(input logic [7:0] c);
    logic [7:0] r;
    r = (c >= 8'h41 && c <= 8'h5A) ? c + 8'h20 : c;
    return r;
  endfunction

  function automatic score_t sat_add(input score_t a, input weight_t w);
    logic signed [48:0] s;
    score_t r;
    s = {a[47], a} + {{17{w[31]}}, w};
    if (s[48] != s[47]) begin
      r = s[48] ? SCORE_MIN : SCORE_MAX;
    end else begin
      r = s[47:0];
    end
    return r;
  endfunction

endpackage

// ----- rtl/core/wkc_ifs.sv -----
// Channel interfaces: input items, results and the configuration write.
// No dependencies.
interface wkc_item_if;
  logic               valid;
  logic               ready;
  logic [1:0]         cmd;
  logic [3:0]         category;
  logic [5:0]         slot;
  logic [4:0]         position;
  logic [7:0]         byte_value;
  logic [5:0]         keyword_length;
  logic signed [31:0] weight;
  modport source(output valid, cmd, category, slot, position, byte_value,
                 keyword_length, weight, input ready);
  modport sink(input valid, cmd, category, slot, position, byte_value,
               keyword_length, weight, output ready);
endinterface

interface wkc_result_if;
  logic               valid;
  logic               ready;
  logic [3:0]         best_category;
  logic               unknown;
  logic signed [47:0] best_score;
  modport source(output valid, best_category, unknown, best_score, input ready);
  modport sink(input valid, best_category, unknown, best_score, output ready);
endinterface

interface wkc_cfg_if;
  logic       valid;
  logic       ready;
  logic [4:0] category_count;
  modport source(output valid, category_count, input ready);
  modport sink(input valid, category_count, output ready);
endinterface

// ----- rtl/core/wkc_queue.sv -----
// Two-entry queue between the front and back halves.
// Generic payload width; no package dependency.
module wkc_queue #(
  parameter int WIDTH = 8
) (
  input  logic             clk,
  input  logic             rst,
  input  logic             push_valid,
  output logic             push_ready,
  input  logic [WIDTH-1:0] push_data,
  output logic             pop_valid,
  input  logic             pop_ready,
  output logic [WIDTH-1:0] pop_data
);
  logic [WIDTH-1:0] mem [2];
  logic             wr_ptr;
  logic             rd_ptr;
  logic [1:0]       count;
  logic             push;
  logic             pop;

  assign push_ready = count != 2'd2;
  assign pop_valid  = count != 2'd0;
  assign pop_data   = mem[rd_ptr];
  assign push       = push_valid && push_ready;
  assign pop        = pop_valid && pop_ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= 1'b0;
      rd_ptr <= 1'b0;
      count  <= 2'd0;
    end else begin
      if (push) wr_ptr <= ~wr_ptr;
      if (pop) rd_ptr <= ~rd_ptr;
      if (push && !pop) count <= count + 2'd1;
      else if (pop && !push) count <= count - 2'd1;
    end
  end

  always_ff @(posedge clk) begin
    if (push) mem[wr_ptr] <= push_data;
  end
endmodule

// ----- rtl/core/wkc_front.sv -----
// Front half: accepts items, range-checks loads, builds tokens.
// Depends on wkc_pkg and wkc_ifs.
module wkc_front import wkc_pkg::*; #(
  parameter int CATEGORIES            = 16,
  parameter int KEYWORDS_PER_CATEGORY = 64,
  parameter int WORD_LEN              = 32,
  localparam int TL_W = $clog2(WORD_LEN + 1),
  localparam int ROW_W = WORD_LEN * 8
) (
  input  logic             clk,
  input  logic             rst,
  wkc_item_if.sink         items,
  input  logic             open,
  output logic             push_valid,
  input  logic             push_ready,
  output wkc_op_t          push_op,
  output logic [ROW_W-1:0] push_tok,
  output logic [TL_W-1:0]  push_len
);
  localparam int PW = (WORD_LEN > 1) ? $clog2(WORD_LEN) : 1;

  logic [ROW_W-1:0] tok_data;
  logic [TL_W-1:0]  tok_len;
  logic             overlong;
  logic             need_push;
  logic             accept;
  logic             delim;
  logic             tok_live;
  logic             addr_ok;
  logic             room;
  logic [PW-1:0]    widx;

  assign delim    = is_delim(items.byte_value);
  assign tok_live = tok_len != '0 && !overlong;
  assign addr_ok  = int'(items.category) < CATEGORIES &&
                    int'(items.slot) < KEYWORDS_PER_CATEGORY;
  assign room     = int'(tok_len) < WORD_LEN;
  assign widx     = PW'(tok_len);

  always_comb begin
    need_push              = 1'b0;
    push_op.kind           = OP_CHAR;
    push_op.flush          = tok_live;
    push_op.category       = items.category;
    push_op.slot           = items.slot;
    push_op.position       = items.position;
    push_op.byte_value     = items.byte_value;
    push_op.keyword_length = items.keyword_length;
    push_op.weight         = items.weight;
    case (cmd_t'(items.cmd))
      CMD_CHAR: begin
        push_op.kind = OP_CHAR;
        need_push    = addr_ok && int'(items.position) < WORD_LEN;
      end
      CMD_KW: begin
        push_op.kind = OP_KW;
        need_push    = addr_ok;
      end
      CMD_TEXT: begin
        push_op.kind = OP_MATCH;
        need_push    = delim && tok_live;
      end
      CMD_END: begin
        push_op.kind = OP_REPORT;
        need_push    = 1'b1;
      end
      default: need_push = 1'b0;
    endcase
  end

  assign items.ready = push_ready && open;
  assign push_valid  = items.valid && open && need_push;
  assign push_tok    = tok_data;
  assign push_len    = tok_len;
  assign accept      = items.valid && items.ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      tok_len  <= '0;
      overlong <= 1'b0;
    end else if (accept) begin
      case (cmd_t'(items.cmd))
        CMD_TEXT: begin
          if (delim) begin
            tok_len  <= '0;
            overlong <= 1'b0;
          end else if (room) begin
            tok_len <= tok_len + TL_W'(1);
          end else begin
            overlong <= 1'b1;
          end
        end
        CMD_END: begin
          tok_len  <= '0;
          overlong <= 1'b0;
        end
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (accept && cmd_t'(items.cmd) == CMD_TEXT && !delim && room) begin
      tok_data[8*widx +: 8] <= items.byte_value;
    end
  end
endmodule

// ----- rtl/core/wkc_back.sv -----
// Back half: keyword store, match walk, category scores and the report.
// Depends on wkc_pkg and wkc_ifs.
module wkc_back import wkc_pkg::*; #(
  parameter int CATEGORIES            = 16,
  parameter int KEYWORDS_PER_CATEGORY = 64,
  parameter int WORD_LEN              = 32,
  localparam int TL_W = $clog2(WORD_LEN + 1),
  localparam int ROW_W = WORD_LEN * 8
) (
  input  logic             clk,
  input  logic             rst,
  wkc_cfg_if.sink          cfg,
  wkc_result_if.source     results,
  input  logic             q_valid,
  output logic             q_ready,
  input  wkc_op_t          q_op,
  input  logic [ROW_W-1:0] q_tok,
  input  logic [TL_W-1:0]  q_tok_len,
  output logic             open
);
  localparam int SLOT_TOTAL = CATEGORIES * KEYWORDS_PER_CATEGORY;
  localparam int KW_AW = (SLOT_TOTAL > 1) ? $clog2(SLOT_TOTAL) : 1;
  localparam int CAT_W = (CATEGORIES > 1) ? $clog2(CATEGORIES) : 1;
  localparam int SL_W  = (KEYWORDS_PER_CATEGORY > 1) ? $clog2(KEYWORDS_PER_CATEGORY) : 1;
  localparam int PW    = (WORD_LEN > 1) ? $clog2(WORD_LEN) : 1;
  localparam logic [KW_AW-1:0] LAST_K  = KW_AW'(SLOT_TOTAL - 1);
  localparam logic [SL_W-1:0]  LAST_SL = SL_W'(KEYWORDS_PER_CATEGORY - 1);

  bk_state_t state, state_next;

  logic [ROW_W-1:0] kw_mem [SLOT_TOTAL];
  logic [37:0]      lw_mem [SLOT_TOTAL];

  logic [KW_AW-1:0] k;
  logic [CAT_W-1:0] cat_cnt;
  logic [SL_W-1:0]  slot_cnt;
  logic             report_pending;
  logic [ROW_W-1:0] tok_data;
  logic [TL_W-1:0]  tok_len;
  logic [ROW_W-1:0] row;
  logic [37:0]      lw_rd;
  logic             s1_v;
  logic [CAT_W-1:0] s1_cat;
  logic             s2_v;
  logic [CAT_W-1:0] s2_cat;
  weight_t          s2_w;
  score_t           score [CATEGORIES];
  logic [4:0]       count;
  logic [CAT_W-1:0] rep_idx;
  score_t           top;
  logic [CAT_W-1:0] best;
  logic             tie;
  logic             res_valid;
  logic [3:0]       res_cat;
  logic             res_unk;
  score_t           res_score;

  logic [KW_AW-1:0] wr_addr;
  logic [PW-1:0]    wr_pos;
  logic             char_we;
  logic             lw_we;
  logic [KW_AW-1:0] lw_addr;
  logic [37:0]      lw_data;
  logic [WORD_LEN-1:0] eq;
  logic             hit;
  logic [CAT_W-1:0] score_idx;
  score_t           rep_s;
  score_t           ntop;
  logic [CAT_W-1:0] nbest;
  logic             ntie;
  logic             nunk;
  logic [6:0]       cnt_eff;
  logic [CAT_W-1:0] last_idx;
  logic             rep_last;
  logic             out_free;
  logic             take_op;

  assign open        = state != BK_CLEAR;
  assign cfg.ready   = 1'b1;
  assign results.valid         = res_valid;
  assign results.best_category = res_cat;
  assign results.unknown       = res_unk;
  assign results.best_score    = res_score;
  assign out_free = !res_valid || results.ready;

  always_ff @(posedge clk) begin
    if (rst) state <= BK_CLEAR;
    else state <= state_next;
  end

  always_comb begin
    state_next = state;
    q_ready    = 1'b0;
    case (state)
      BK_CLEAR: if (k == LAST_K) state_next = BK_IDLE;
      BK_IDLE: begin
        q_ready = 1'b1;
        if (q_valid) begin
          case (q_op.kind)
            OP_MATCH:  state_next = BK_MATCH;
            OP_REPORT: state_next = q_op.flush ? BK_MATCH : BK_REPORT;
            default:   state_next = BK_IDLE;
          endcase
        end
      end
      BK_MATCH: if (k == LAST_K) state_next = BK_DRAIN;
      BK_DRAIN: if (!s1_v && !s2_v) state_next = report_pending ? BK_REPORT : BK_IDLE;
      BK_REPORT: if (rep_last && out_free) state_next = BK_IDLE;
      default: state_next = BK_CLEAR;
    endcase
  end

  assign take_op = state == BK_IDLE && q_valid;
  assign wr_addr = KW_AW'(q_op.category) * KW_AW'(KEYWORDS_PER_CATEGORY) + KW_AW'(q_op.slot);
  assign wr_pos  = PW'(q_op.position);
  assign char_we = take_op && q_op.kind == OP_CHAR;
  assign lw_we   = state == BK_CLEAR || (take_op && q_op.kind == OP_KW);
  assign lw_addr = (state == BK_CLEAR) ? k : wr_addr;
  assign lw_data = (state == BK_CLEAR) ? 38'd0 : {q_op.keyword_length, q_op.weight};

  always_ff @(posedge clk) begin
    if (char_we) kw_mem[wr_addr][8*wr_pos +: 8] <= q_op.byte_value;
    if (lw_we) lw_mem[lw_addr] <= lw_data;
    row   <= kw_mem[k];
    lw_rd <= lw_mem[k];
  end

  // keyword compare on the registered row
  always_comb begin
    for (int p = 0; p < WORD_LEN; p++) begin
      eq[p] = (p >= int'(tok_len)) || (fold(row[8*p +: 8]) == fold(tok_data[8*p +: 8]));
    end
    hit = (int'(lw_rd[37:32]) == int'(tok_len)) && (&eq);
  end

  // report walk, one category per cycle
  always_comb begin
    score_idx = (state == BK_REPORT) ? rep_idx : s2_cat;
    rep_s     = score[score_idx];
    ntop      = top;
    nbest     = best;
    ntie      = tie;
    if (rep_idx == '0) begin
      ntop  = rep_s;
      nbest = '0;
      ntie  = 1'b0;
    end else if (rep_s > top) begin
      ntop  = rep_s;
      nbest = rep_idx;
      ntie  = 1'b0;
    end else if (rep_s == top) begin
      ntie = 1'b1;
    end
    nunk = (ntop <= 48'sd0) || ntie;
    if (count == 5'd0) cnt_eff = 7'd1;
    else if (7'(count) > 7'(CATEGORIES)) cnt_eff = 7'(CATEGORIES);
    else cnt_eff = 7'(count);
    last_idx = CAT_W'(cnt_eff - 7'd1);
    rep_last = rep_idx == last_idx;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      k              <= '0;
      cat_cnt        <= '0;
      slot_cnt       <= '0;
      report_pending <= 1'b0;
      s1_v           <= 1'b0;
      s2_v           <= 1'b0;
      count          <= 5'd1;
      rep_idx        <= '0;
      res_valid      <= 1'b0;
      for (int c = 0; c < CATEGORIES; c++) score[c] <= '0;
    end else begin
      if (cfg.valid) count <= cfg.category_count;
      s1_v <= state == BK_MATCH;
      s2_v <= s1_v && hit;
      if (s2_v) score[s2_cat] <= sat_add(score[s2_cat], s2_w);
      if (res_valid && results.ready) res_valid <= 1'b0;
      case (state)
        BK_CLEAR: k <= (k == LAST_K) ? '0 : k + KW_AW'(1);
        BK_IDLE: begin
          if (q_valid && (q_op.kind == OP_MATCH || q_op.kind == OP_REPORT)) begin
            report_pending <= q_op.kind == OP_REPORT;
            k        <= '0;
            cat_cnt  <= '0;
            slot_cnt <= '0;
            rep_idx  <= '0;
          end
        end
        BK_MATCH: begin
          k <= (k == LAST_K) ? '0 : k + KW_AW'(1);
          if (slot_cnt == LAST_SL) begin
            slot_cnt <= '0;
            cat_cnt  <= cat_cnt + CAT_W'(1);
          end else begin
            slot_cnt <= slot_cnt + SL_W'(1);
          end
        end
        BK_REPORT: begin
          if (!rep_last) begin
            rep_idx <= rep_idx + CAT_W'(1);
          end else if (out_free) begin
            res_valid <= 1'b1;
            for (int c = 0; c < CATEGORIES; c++) score[c] <= '0;
          end
        end
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (take_op && (q_op.kind == OP_MATCH || q_op.kind == OP_REPORT)) begin
      tok_data <= q_tok;
      tok_len  <= q_tok_len;
    end
    s1_cat <= cat_cnt;
    s2_cat <= s1_cat;
    s2_w   <= weight_t'(lw_rd[31:0]);
    // running max holds still while the last category waits on the output
    if (state == BK_REPORT && !rep_last) begin
      top  <= ntop;
      best <= nbest;
      tie  <= ntie;
    end
    if (state == BK_REPORT && rep_last && out_free) begin
      res_cat   <= nunk ? 4'd0 : 4'(nbest);
      res_unk   <= nunk;
      res_score <= ntop;
    end
  end
endmodule

// ----- rtl/core/weighted_keyword_classifier.sv -----
// Weighted keyword classifier, top level.
// Depends on wkc_pkg, wkc_ifs, wkc_front, wkc_queue, wkc_back and the defines header.
//
// After reset the block walks every keyword slot, clearing the keyword length
// store, and takes no item meanwhile; config writes are taken at any time.
// Keyword loads and document bytes are taken only while the queue has room.
// Every token that ends, unless it ran past WORD_LEN bytes, walks the whole keyword
// store through its single read port, one keyword per cycle, before the back half
// takes its next beat.
// An end-of-document beat adds that walk if a token is pending, then steps through
// the compared categories in turn; the result is registered once the output is free.
// A two-beat queue lets bytes keep arriving while a walk runs; the result register
// frees the input side while a result waits.
`include "weighted_keyword_classifier_defines.svh"

module weighted_keyword_classifier import wkc_pkg::*; #(
  parameter int CATEGORIES            = 16,
  parameter int KEYWORDS_PER_CATEGORY = 64,
  parameter int WORD_LEN              = 32
) (
  input  logic         clk,
  input  logic         rst,
  wkc_item_if.sink     items,
  wkc_result_if.source results,
  wkc_cfg_if.sink      cfg
);
  localparam int TL_W  = $clog2(WORD_LEN + 1);
  localparam int ROW_W = WORD_LEN * 8;
  localparam int OP_W  = $bits(wkc_op_t);
  localparam int QW    = OP_W + ROW_W + TL_W;

  logic             open;
  logic             push_valid;
  logic             push_ready;
  wkc_op_t          push_op;
  logic [ROW_W-1:0] push_tok;
  logic [TL_W-1:0]  push_len;
  logic             pop_valid;
  logic             pop_ready;
  logic [QW-1:0]    pop_data;
  wkc_op_t          q_op;

  wkc_front #(
    .CATEGORIES(CATEGORIES),
    .KEYWORDS_PER_CATEGORY(KEYWORDS_PER_CATEGORY),
    .WORD_LEN(WORD_LEN)
  ) u_front (
    .clk(clk), .rst(rst), .items(items), .open(open),
    .push_valid(push_valid), .push_ready(push_ready),
    .push_op(push_op), .push_tok(push_tok), .push_len(push_len)
  );

  wkc_queue #(.WIDTH(QW)) u_queue (
    .clk(clk), .rst(rst),
    .push_valid(push_valid), .push_ready(push_ready),
    .push_data({push_tok, push_len, push_op}),
    .pop_valid(pop_valid), .pop_ready(pop_ready), .pop_data(pop_data)
  );

  assign q_op = wkc_op_t'(pop_data[OP_W-1:0]);

  wkc_back #(
    .CATEGORIES(CATEGORIES),
    .KEYWORDS_PER_CATEGORY(KEYWORDS_PER_CATEGORY),
    .WORD_LEN(WORD_LEN)
  ) u_back (
    .clk(clk), .rst(rst), .cfg(cfg), .results(results),
    .q_valid(pop_valid), .q_ready(pop_ready), .q_op(q_op),
    .q_tok(pop_data[QW-1 -: ROW_W]), .q_tok_len(pop_data[OP_W +: TL_W]),
    .open(open)
  );

  `WKC_ASSERT_IMP(a_closed_no_beat, !open, !items.ready)
  `WKC_ASSERT_NXT(a_open_stays, open, open)
  `WKC_ASSERT_IMP(a_unknown_zero, results.valid && results.unknown, results.best_category == 4'd0)
  `WKC_ASSERT_IMP(a_known_positive, results.valid && !results.unknown, results.best_score > 48'sd0)
endmodule
